@@ hdl/maze_backtracker_carver_defines.svh @@
// Assertion macros used by the maze carver datapath.
`ifndef MAZE_BACKTRACKER_CARVER_DEFINES_SVH
`define MAZE_BACKTRACKER_CARVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MBC_CHECK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("maze carver check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define MBC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("maze carver check failed");

`endif

@@ hdl/mbc_pkg.sv @@
// Shared types and constants of the maze carver.
`timescale 1ns / 1ps
`default_nettype none
package mbc_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int RND_W     = 32;
  localparam int COORD_W   = 6;
  localparam int DIR_W     = 2;
  localparam int SIZE_W    = 9;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 7'd40;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 7'd40;

  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 1'b1;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_CARVE   = 1'b1;

  localparam logic [DIR_W-1:0] DIR_PX = 2'd0;
  localparam logic [DIR_W-1:0] DIR_MX = 2'd1;
  localparam logic [DIR_W-1:0] DIR_PY = 2'd2;
  localparam logic [DIR_W-1:0] DIR_MY = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_NB_RD,
    ST_NB_WAIT,
    ST_DECIDE
  } mbc_state_t;

  typedef struct packed {
    logic             capture;
    logic             clear_step;
    logic             init;
    logic             top_read;
    logic             top_latch;
    logic             nb_read;
    logic [DIR_W-1:0] nb_dir;
    logic             pop;
    logic             carve;
    logic             done;
  } mbc_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic clear_last;
    logic mask_zero;
    logic out_free;
  } mbc_stat_t;

endpackage
`default_nettype wire

@@ hdl/mbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/mbc_ctrl.sv @@
// Sequencer of the maze carver: restart sweep and the pop/examine/carve loop.
`timescale 1ns / 1ps
`default_nettype none
module mbc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  output logic                   in_ready,
  input  wire mbc_pkg::mbc_stat_t stat,
  output mbc_pkg::mbc_cmd_t       cmd
);

  mbc_pkg::mbc_state_t         state, state_next;
  logic [mbc_pkg::DIR_W-1:0]   nb_cnt, nb_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mbc_pkg::ST_IDLE;
      nb_cnt <= '0;
    end else begin
      state  <= state_next;
      nb_cnt <= nb_cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    nb_cnt_next = nb_cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.nb_dir  = nb_cnt;
    case (state)
      mbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (in_kind == mbc_pkg::KIND_CARVE) ? mbc_pkg::ST_TOP_RD
                                                         : mbc_pkg::ST_CLEAR;
        end
      end
      mbc_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = mbc_pkg::ST_INIT;
        end
      end
      mbc_pkg::ST_INIT: begin
        if (stat.out_free) begin
          cmd.init   = 1'b1;
          state_next = mbc_pkg::ST_IDLE;
        end
      end
      mbc_pkg::ST_TOP_RD: begin
        if (stat.count_zero) begin
          // stack exhausted: report done once the output word is free
          if (stat.out_free) begin
            cmd.done   = 1'b1;
            state_next = mbc_pkg::ST_IDLE;
          end
        end else begin
          cmd.top_read = 1'b1;
          state_next   = mbc_pkg::ST_TOP_WAIT;
        end
      end
      mbc_pkg::ST_TOP_WAIT: begin
        cmd.top_latch = 1'b1;
        nb_cnt_next   = '0;
        state_next    = mbc_pkg::ST_NB_RD;
      end
      mbc_pkg::ST_NB_RD: begin
        cmd.nb_read = 1'b1;
        nb_cnt_next = nb_cnt + 2'd1;
        if (nb_cnt == mbc_pkg::DIR_MY) begin
          state_next = mbc_pkg::ST_NB_WAIT;
        end
      end
      mbc_pkg::ST_NB_WAIT: begin
        state_next = mbc_pkg::ST_DECIDE;
      end
      mbc_pkg::ST_DECIDE: begin
        if (stat.mask_zero) begin
          cmd.pop    = 1'b1;
          state_next = mbc_pkg::ST_TOP_RD;
        end else if (stat.out_free) begin
          cmd.carve  = 1'b1;
          state_next = mbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/mbc_datapath.sv @@
// Datapath of the maze carver: size registers, visited map, cell stack, pick and result word.
`timescale 1ns / 1ps
`default_nettype none
`include "maze_backtracker_carver_defines.svh"
module mbc_datapath #(
  parameter int MAX_WIDTH  = mbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [mbc_pkg::RND_W-1:0]     rnd_in,
  input  wire mbc_pkg::mbc_cmd_t              cmd,
  output mbc_pkg::mbc_stat_t                  stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [15:0]                        out_data,
  output logic [1:0]                         out_user
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int CW = AW + 1;
  localparam int SW = mbc_pkg::SIZE_W;
  localparam logic [CW-1:0] CELLS = CW'(1) << AW;
  localparam logic [SW-1:0] MAXW  = SW'(MAX_WIDTH);
  localparam logic [SW-1:0] MAXH  = SW'(MAX_HEIGHT);

  // random_word mod 3, folded through 256 = 16 = 4 = 1 (mod 3)
  function automatic logic [1:0] mod3_32(input logic [31:0] v);
    logic [9:0] s10;
    logic [5:0] s6;
    logic [3:0] s4;
    logic [1:0] r;
    s10 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
    s6  = 6'(s10[3:0]) + 6'(s10[7:4]) + 6'(s10[9:8]);
    s4  = 4'(s6[1:0]) + 4'(s6[3:2]) + 4'(s6[5:4]);
    case (s4)
      4'd0, 4'd3, 4'd6, 4'd9: r = 2'd0;
      4'd1, 4'd4, 4'd7:       r = 2'd1;
      4'd2, 4'd5, 4'd8:       r = 2'd2;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  // direction of the k-th set bit of the candidate mask, scanning +x, -x, +y, -y
  function automatic logic [1:0] pick_dir(input logic [3:0] mask, input logic [1:0] k);
    logic [1:0] seen;
    logic [1:0] d;
    seen = '0;
    d    = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == k) begin
          d = 2'(i);
        end
        seen = seen + 2'd1;
      end
    end
    return d;
  endfunction

  logic [mbc_pkg::CFG_W-1:0] width_reg, height_reg;
  logic [SW-1:0]             w_eff, h_eff;

  logic [1:0]    rnd_lo, rnd_m3;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] count, count_m1;
  logic          stack_full;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [SW-1:0] x9, y9;
  logic [3:0]    inb, nb_mask;
  logic          nb_pend;
  logic [1:0]    nb_dir_q;

  logic [2:0]    n_cand;
  logic [1:0]    k_sel, sel_dir;
  logic [SW-1:0] rd_nx, rd_ny, new_nx, new_ny;
  logic [AW-1:0] rd_addr, new_addr;

  logic          vis_we, vis_wdata, vis_rdata;
  logic [AW-1:0] vis_waddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_wdata, stk_rdata;

  logic                        res_carved, res_done;
  logic [mbc_pkg::COORD_W-1:0] res_x, res_y;
  logic [mbc_pkg::DIR_W-1:0]   res_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= mbc_pkg::RESET_WIDTH;
      height_reg <= mbc_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        mbc_pkg::CFG_MAZE_WIDTH:  width_reg  <= cfg_data;
        mbc_pkg::CFG_MAZE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes to 1..MAX
  always_comb begin
    if (width_reg == '0)            w_eff = SW'(1);
    else if (SW'(width_reg) > MAXW) w_eff = MAXW;
    else                            w_eff = SW'(width_reg);
    if (height_reg == '0)            h_eff = SW'(1);
    else if (SW'(height_reg) > MAXH) h_eff = MAXH;
    else                             h_eff = SW'(height_reg);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rnd_lo <= rnd_in[1:0];
      rnd_m3 <= mod3_32(rnd_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.capture) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign count_m1   = count - CW'(1);
  assign stack_full = (count == CELLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.init) begin
      count <= CW'(1);
    end else if (cmd.carve && !stack_full) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.top_latch) begin
      x_r <= stk_rdata[XW-1:0];
      y_r <= stk_rdata[AW-1:XW];
    end
  end

  assign x9 = SW'(x_r);
  assign y9 = SW'(y_r);

  // in-bounds test of each neighbor against the current size
  always_comb begin
    inb[mbc_pkg::DIR_PX] = (x9 + SW'(1) < w_eff) && (y9 < h_eff);
    inb[mbc_pkg::DIR_MX] = (x9 != '0) && (x9 - SW'(1) < w_eff) && (y9 < h_eff);
    inb[mbc_pkg::DIR_PY] = (x9 < w_eff) && (y9 + SW'(1) < h_eff);
    inb[mbc_pkg::DIR_MY] = (x9 < w_eff) && (y9 != '0) && (y9 - SW'(1) < h_eff);
  end

  always_comb begin
    rd_nx = x9;
    rd_ny = y9;
    case (cmd.nb_dir)
      mbc_pkg::DIR_PX: rd_nx = x9 + SW'(1);
      mbc_pkg::DIR_MX: rd_nx = x9 - SW'(1);
      mbc_pkg::DIR_PY: rd_ny = y9 + SW'(1);
      mbc_pkg::DIR_MY: rd_ny = y9 - SW'(1);
      default: ;
    endcase
  end
  assign rd_addr = {rd_ny[YW-1:0], rd_nx[XW-1:0]};

  // visited bit returns in the cycle after the read; fold it into the mask
  always_ff @(posedge clk) begin
    if (rst) begin
      nb_pend <= 1'b0;
    end else begin
      nb_pend <= cmd.nb_read;
    end
  end

  always_ff @(posedge clk) begin
    nb_dir_q <= cmd.nb_dir;
    if (nb_pend) begin
      nb_mask[nb_dir_q] <= inb[nb_dir_q] & ~vis_rdata;
    end
  end

  assign n_cand = 3'($countones(nb_mask));

  always_comb begin
    case (n_cand)
      3'd2:    k_sel = {1'b0, rnd_lo[0]};
      3'd3:    k_sel = rnd_m3;
      3'd4:    k_sel = rnd_lo;
      default: k_sel = 2'd0;
    endcase
  end

  assign sel_dir = pick_dir(nb_mask, k_sel);

  always_comb begin
    new_nx = x9;
    new_ny = y9;
    case (sel_dir)
      mbc_pkg::DIR_PX: new_nx = x9 + SW'(1);
      mbc_pkg::DIR_MX: new_nx = x9 - SW'(1);
      mbc_pkg::DIR_PY: new_ny = y9 + SW'(1);
      mbc_pkg::DIR_MY: new_ny = y9 - SW'(1);
      default: ;
    endcase
  end
  assign new_addr = {new_ny[YW-1:0], new_nx[XW-1:0]};

  always_comb begin
    vis_we    = cmd.clear_step || cmd.init || cmd.carve;
    vis_wdata = !cmd.clear_step;
    if (cmd.clear_step)  vis_waddr = clr_addr;
    else if (cmd.init)   vis_waddr = '0;
    else                 vis_waddr = new_addr;
    stk_we    = cmd.init || (cmd.carve && !stack_full);
    stk_waddr = cmd.init ? '0 : count[AW-1:0];
    stk_wdata = cmd.init ? '0 : new_addr;
  end

  mbc_ram #(
    .WIDTH(1),
    .DEPTH(1 << AW)
  ) u_visited (
    .clk  (clk),
    .we   (vis_we),
    .waddr(vis_waddr),
    .wdata(vis_wdata),
    .raddr(rd_addr),
    .rdata(vis_rdata)
  );

  mbc_ram #(
    .WIDTH(AW),
    .DEPTH(1 << AW)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(count_m1[AW-1:0]),
    .rdata(stk_rdata)
  );

  // result word: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.init || cmd.carve || cmd.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init || cmd.done) begin
      res_carved <= 1'b0;
      res_x      <= '0;
      res_y      <= '0;
      res_dir    <= mbc_pkg::DIR_PX;
      res_done   <= cmd.done;
    end else if (cmd.carve) begin
      res_carved <= 1'b1;
      res_x      <= x9[mbc_pkg::COORD_W-1:0];
      res_y      <= y9[mbc_pkg::COORD_W-1:0];
      res_dir    <= sel_dir;
      res_done   <= 1'b0;
    end
  end

  assign out_data = {2'b00, res_dir, res_y, res_x};
  assign out_user = {res_done, res_carved};

  always_comb begin
    stat            = '0;
    stat.count_zero = (count == '0);
    stat.clear_last = (clr_addr == '1);
    stat.mask_zero  = (nb_mask == '0);
    stat.out_free   = !out_valid || out_ready;
  end

  `MBC_CHECK_IMPL(a_load_free, cmd.init || cmd.carve || cmd.done, !out_valid || out_ready)
  `MBC_CHECK_IMPL(a_carve_cand, cmd.carve, nb_mask != '0)
  `MBC_CHECK_IMPL(a_read_nonempty, cmd.top_read || cmd.pop, count != '0)
  `MBC_CHECK_NEXT(a_push_count, cmd.carve && !stack_full, count == $past(count) + CW'(1))

endmodule
`default_nettype wire

@@ hdl/maze_backtracker_carver.sv @@
// Top level of the depth-first maze carver.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: kind; tdata: random_word
//  m_       | out       | m_tvalid/m_tready  | tuser: carved, done_res; tdata: x,y,dir
//  cfg_     | in        | cfg_we             | index 0 maze_width, 1 maze_height
//
//  A carve word works through the stack top by top, popping each cell with no free
//  neighbor: each stack top costs one stack read, one latch, four visited-map reads,
//  a wait state and a decide state. A carve word on an empty stack reports done.
//  A restart word sweeps all 2**(XW+YW) entries of the visited map, one entry a
//  cycle, before cell (0,0) is marked and pushed.
//  Reset is synchronous; the visited map is swept by each restart, not by reset.
//  A stalled result holds in the output register; the next word is accepted
//  and worked on meanwhile, waiting only where it must load its own result.
`timescale 1ns / 1ps
`default_nettype none
module maze_backtracker_carver #(
  parameter int MAX_WIDTH  = mbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,  // [31:0] random_word
  input  wire logic                          s_tuser,  // [0] kind
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata,  // [5:0] from_x, [11:6] from_y,
                                                       // [13:12] direction, [15:14] zero
  output logic [1:0]                         m_tuser   // [0] carved, [1] done_res
);

  mbc_pkg::mbc_cmd_t  cmd;
  mbc_pkg::mbc_stat_t stat;

  mbc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_kind (s_tuser),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  mbc_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rnd_in   (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_data (m_tdata),
    .out_user (m_tuser)
  );

endmodule
`default_nettype wire

@@ sim/maze_backtracker_carver_tb.sv @@
// Self-checking testbench for the depth-first maze carver: random stream traffic against a predictor.
`timescale 1ns / 1ps
module maze_backtracker_carver_tb;
  import mbc_pkg::*;

  localparam int GRID_W = DEF_MAX_WIDTH;
  localparam int GRID_H = DEF_MAX_HEIGHT;
  localparam int GRID_CELLS = GRID_W * GRID_H;
  localparam int CELL_W = $clog2(GRID_CELLS);
  localparam int ITEM_TARGET = 770;
  // A restart sweeps the whole map; even a run made only of
  // restarts behind the slowest receiver stays well below this.
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic             kind;
    logic [RND_W-1:0] rnd;
  } maze_word_t;

  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [DIR_W-1:0]   direction;
    logic               done_res;
  } passage_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_SLOW} rx_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;  // [31:0] random_word
  logic s_tuser = 1'b0;       // [0] kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;       // [5:0] from_x, [11:6] from_y, [13:12] direction
  logic [1:0] m_tuser;        // [0] carved, [1] done_res

  maze_backtracker_carver dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Predictor state: visited map, cell stack and the size registers.
  bit visited_cells [GRID_CELLS];
  logic [CELL_W-1:0] cell_trail [GRID_CELLS];
  int trail_depth = 0;
  logic [CFG_W-1:0] width_reg = RESET_WIDTH;
  logic [CFG_W-1:0] height_reg = RESET_HEIGHT;
  logic last_done = 1'b0;

  maze_word_t pending_words [$];
  passage_t expected_passages [$];
  int words_queued = 0;
  int mismatches = 0;
  int cycle_count = 0;

  maze_word_t next_word;
  passage_t want;
  int burst_left = 1;
  int gap_left = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  int rx_pattern_left = 0;
  int cells;
  int chunks;

  function automatic int span(input logic [CFG_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic passage_t carve_step(input logic kind, input logic [RND_W-1:0] rnd);
    passage_t res;
    int w, h, x, y, nx, ny;
    int unsigned n, pick;
    logic [DIR_W-1:0] cand_dir [4];
    int cand_cell [4];
    logic [DIR_W-1:0] dir;
    logic [CELL_W-1:0] top;
    res = '0;
    w = span(width_reg, GRID_W);
    h = span(height_reg, GRID_H);
    if (kind == KIND_RESTART) begin
      foreach (visited_cells[i]) visited_cells[i] = 1'b0;
      visited_cells[0] = 1'b1;
      cell_trail[0] = '0;
      trail_depth = 1;
      return res;
    end
    while (trail_depth > 0) begin
      top = cell_trail[trail_depth - 1];
      x = top % GRID_W;
      y = top / GRID_W;
      n = 0;
      for (int k = 0; k < 4; k++) begin
        dir = DIR_W'(k);
        nx = x;
        ny = y;
        case (dir)
          DIR_PX: nx = x + 1;
          DIR_MX: nx = x - 1;
          DIR_PY: ny = y + 1;
          default: ny = y - 1;
        endcase
        if (nx >= 0 && nx < w && ny >= 0 && ny < h && !visited_cells[ny * GRID_W + nx]) begin
          cand_dir[n] = dir;
          cand_cell[n] = ny * GRID_W + nx;
          n++;
        end
      end
      if (n == 0) begin
        // dead end: backtrack
        trail_depth--;
      end else begin
        pick = rnd % n;
        visited_cells[cand_cell[pick]] = 1'b1;
        if (trail_depth < GRID_CELLS) begin
          cell_trail[trail_depth] = CELL_W'(cand_cell[pick]);
          trail_depth++;
        end
        res.carved = 1'b1;
        res.from_x = COORD_W'(x);
        res.from_y = COORD_W'(y);
        res.direction = cand_dir[pick];
        return res;
      end
    end
    res.done_res = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic logic [RND_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 7);
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input logic kind, input logic [RND_W-1:0] rnd);
    maze_word_t w;
    w.kind = kind;
    w.rnd = rnd;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAZE_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // Hold until every queued word is taken and every result has come back.
  task automatic wait_idle();
    while (pending_words.size() != 0 || s_tvalid || expected_passages.size() != 0)
      @(posedge clk);
  endtask

  task automatic resize_maze();
    logic [CFG_W-1:0] w, h;
    case ($urandom_range(0, 15))
      0: begin
        w = 7'd64;
        h = CFG_W'($urandom_range(1, 2));
      end
      1: begin
        w = CFG_W'($urandom_range(1, 2));
        h = 7'd64;
      end
      2: begin
        w = $urandom_range(0, 1) ? 7'd0 : CFG_W'($urandom_range(65, 127));
        h = CFG_W'($urandom_range(1, 3));
      end
      3: begin
        w = CFG_W'($urandom_range(1, 3));
        h = $urandom_range(0, 1) ? 7'd0 : CFG_W'($urandom_range(65, 127));
      end
      default: begin
        w = CFG_W'($urandom_range(1, 8));
        h = CFG_W'($urandom_range(1, 8));
      end
    endcase
    write_size(CFG_MAZE_WIDTH, w);
    write_size(CFG_MAZE_HEIGHT, h);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: bursts of words with random gaps in between.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        want = carve_step(s_tuser, s_tdata);
        last_done = want.done_res;
        expected_passages.insert(expected_passages.size(), want);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          next_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_word.kind;
          s_tdata <= next_word.rnd;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver: switch between stall patterns picked at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_pattern_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_pattern_left = $urandom_range(20, 300);
      end else begin
        rx_pattern_left--;
      end
      case (rx_pattern)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        RX_CHOKE: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_passages.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: tuser %b tdata %h",
                                  m_tuser, m_tdata));
      end else begin
        want = expected_passages.pop_front();
        if (m_tuser[0] !== want.carved)
          report_mismatch($sformatf("carved: got %b, expected %b", m_tuser[0], want.carved));
        if (m_tuser[1] !== want.done_res)
          report_mismatch($sformatf("done_res: got %b, expected %b", m_tuser[1], want.done_res));
        if (m_tdata[5:0] !== want.from_x)
          report_mismatch($sformatf("from_x: got %0d, expected %0d", m_tdata[5:0], want.from_x));
        if (m_tdata[11:6] !== want.from_y)
          report_mismatch($sformatf("from_y: got %0d, expected %0d", m_tdata[11:6], want.from_y));
        if (m_tdata[13:12] !== want.direction)
          report_mismatch($sformatf("direction: got %0d, expected %0d",
                                    m_tdata[13:12], want.direction));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_passages.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    @(posedge clk);

    // carve with an empty stack reports done
    queue_word(KIND_CARVE, '1);
    wait_idle();

    // single-cell maze: nothing to carve
    write_size(CFG_MAZE_WIDTH, 7'd1);
    write_size(CFG_MAZE_HEIGHT, 7'd1);
    queue_word(KIND_RESTART, '0);
    queue_word(KIND_CARVE, '0);
    queue_word(KIND_CARVE, '1);
    wait_idle();

    // 2x2 with extreme random words
    write_size(CFG_MAZE_WIDTH, 7'd2);
    write_size(CFG_MAZE_HEIGHT, 7'd2);
    queue_word(KIND_RESTART, '1);
    queue_word(KIND_CARVE, '0);
    queue_word(KIND_CARVE, '1);
    queue_word(KIND_CARVE, 32'h8000_0000);
    queue_word(KIND_CARVE, '0);
    wait_idle();

    // zero width clamps to one column
    write_size(CFG_MAZE_WIDTH, 7'd0);
    write_size(CFG_MAZE_HEIGHT, 7'd3);
    queue_word(KIND_RESTART, 32'h5555_5555);
    queue_word(KIND_CARVE, 32'hAAAA_AAAA);
    queue_word(KIND_CARVE, 32'd3);
    queue_word(KIND_CARVE, 32'd2);
    wait_idle();

    // shrink the grid mid-maze so stacked cells fall outside it
    write_size(CFG_MAZE_WIDTH, 7'd3);
    write_size(CFG_MAZE_HEIGHT, 7'd3);
    queue_word(KIND_RESTART, '0);
    queue_word(KIND_CARVE, 32'd1);
    queue_word(KIND_CARVE, 32'd2);
    queue_word(KIND_CARVE, 32'd3);
    queue_word(KIND_CARVE, 32'h7FFF_FFFF);
    wait_idle();
    write_size(CFG_MAZE_WIDTH, 7'd2);
    write_size(CFG_MAZE_HEIGHT, 7'd127);
    write_size(CFG_MAZE_HEIGHT, 7'd2);
    queue_word(KIND_CARVE, 32'd1);
    queue_word(KIND_CARVE, 32'd0);
    queue_word(KIND_CARVE, '1);
    wait_idle();

    while (words_queued < ITEM_TARGET) begin
      resize_maze();
      cells = span(width_reg, GRID_W) * span(height_reg, GRID_H);
      queue_word(KIND_RESTART, pick_word());
      case ($urandom_range(0, 9))
        0: begin
          // cut short by the next restart
          repeat ($urandom_range(0, cells - 1)) queue_word(KIND_CARVE, pick_word());
        end
        1: begin
          // resize partway through, then carve until done
          repeat ($urandom_range(0, cells - 1)) queue_word(KIND_CARVE, pick_word());
          wait_idle();
          resize_maze();
          chunks = 0;
          while (!last_done && chunks < 40) begin
            repeat (8) queue_word(KIND_CARVE, pick_word());
            wait_idle();
            chunks++;
          end
        end
        2: begin
          repeat ($urandom_range(1, 6)) queue_word(1'($urandom_range(0, 1)), pick_word());
        end
        default: begin
          repeat (cells - 1 + $urandom_range(1, 3)) queue_word(KIND_CARVE, pick_word());
        end
      endcase
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mbc_pkg.sv
hdl/mbc_ram.sv
hdl/mbc_ctrl.sv
hdl/mbc_datapath.sv
hdl/maze_backtracker_carver.sv
sim/maze_backtracker_carver_tb.sv
